FILE: hdl/rpcc_pkg.sv
// Shared constants, command prefix table and hex decoding for the RSP packet checker.
package rpcc_pkg;

	localparam int NUM_CLASSES  = 24;
	localparam int NUM_PREFIXES = 23;
	localparam int PREFIX_MAX   = 15;
	localparam int CLASS_W      = 5;

	localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = CLASS_W'(NUM_CLASSES - 1);

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_HASH   = 8'h23;

	typedef logic [8*PREFIX_MAX-1:0] prefix_text_t;

	// Text is right-justified: the last character of a prefix sits in the low byte.
	localparam prefix_text_t PREFIX_TEXT [NUM_PREFIXES] = '{
		"qSupported", "qTStatus", "qXfer", "qRcmd", "QStartNoAckMode",
		"vMustReplyEmpty", "vCont", "?", "g", "G", "m", "M", "c", "s", "!",
		"Hg", "Hc", "OK", "E", "S", "T", "W", "O"
	};

	localparam logic [3:0] PREFIX_LEN [NUM_PREFIXES] = '{
		4'd10, 4'd8, 4'd5, 4'd5, 4'd15,
		4'd15, 4'd5, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd2, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
	};

	// Character of prefix idx at data position pos; meaningful only for pos below its length.
	function automatic logic [7:0] prefix_char(input int idx, input logic [3:0] pos);
		logic [3:0] sh;
		sh = PREFIX_LEN[idx] - 4'd1 - pos;
		return PREFIX_TEXT[idx][{sh, 3'b000} +: 8];
	endfunction

	// Bit 4 flags a valid hex digit, bits 3..0 hold its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

FILE: hdl/rsp_packet_checker_counter_core.sv
// A frame result passes through stage one and then the output queue before it is offered.
// One byte per cycle while in_ready is high; a frame is at least four bytes, so results come
// at most one per four bytes; the per-class counter read-modify-write never overlaps itself.
// Input stalls only on a final checksum byte while stage one and the queue hold two results.
// Reset clears the framer and marks all 24 counters invalid; an invalid counter reads as zero,
// so no clearing pass over the counter RAM is needed.
module rsp_packet_checker_counter_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   data_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rpcc_pkg::CLASS_W-1:0] command_class,
	output logic                         checksum_ok,
	output logic [7:0]                   computed_sum,
	output logic [7:0]                   received_sum,
	output logic [COUNT_WIDTH-1:0]       class_count
);

	import rpcc_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_DATA, PH_DIG1, PH_DIG2} phase_t;

	phase_t                  phase_q;
	logic [7:0]              sum_q;
	logic [3:0]              pos_q;
	logic [NUM_PREFIXES-1:0] alive_q;
	logic [4:0]              dig1_q;

	logic                    in_fire;
	logic                    finish;
	logic [4:0]              hex;
	logic                    rx_valid;
	logic [7:0]              rsum;
	logic                    ok;
	logic [CLASS_W-1:0]      cls;
	logic [NUM_PREFIXES-1:0] alive_next;

	logic                    valid_s1;
	logic [CLASS_W-1:0]      cls_s1;
	logic                    ok_s1;
	logic [7:0]              csum_s1;
	logic [7:0]              rsum_s1;

	logic [NUM_CLASSES-1:0]  cnt_valid_q;
	logic [COUNT_WIDTH-1:0]  ram_rdata;
	logic [COUNT_WIDTH-1:0]  cur_count;
	logic [COUNT_WIDTH-1:0]  new_count;
	logic                    ram_we;

	logic [CLASS_W-1:0]      q_cls_q    [2];
	logic                    q_ok_q     [2];
	logic [7:0]              q_csum_q   [2];
	logic [7:0]              q_rsum_q   [2];
	logic [COUNT_WIDTH-1:0]  q_clscnt_q [2];
	logic                    q_wr_q;
	logic                    q_rd_q;
	logic [1:0]              q_count_q;
	logic                    pop;

	// A finishing byte needs a free queue slot for its result once it leaves stage one.
	assign in_ready = (phase_q != PH_DIG2) || (({1'b0, valid_s1} + q_count_q) < 2'd2);
	assign in_fire  = in_valid && in_ready;
	assign finish   = in_fire && (phase_q == PH_DIG2);

	assign hex      = hex_decode(data_byte);
	assign rx_valid = dig1_q[4] && hex[4];
	assign rsum     = rx_valid ? {dig1_q[3:0], hex[3:0]} : 8'h00;
	assign ok       = rx_valid && (rsum == sum_q);

	// Lowest-index prefix that is still alive and fully seen wins.
	always_comb begin
		cls = CLASS_UNKNOWN;
		for (int i = NUM_PREFIXES - 1; i >= 0; i--) begin
			if (alive_q[i] && (pos_q >= PREFIX_LEN[i])) begin
				cls = CLASS_W'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_PREFIXES; i++) begin
			alive_next[i] = alive_q[i] &&
				!((pos_q < PREFIX_LEN[i]) && (prefix_char(i, pos_q) != data_byte));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sum_q   <= 8'h00;
			pos_q   <= 4'd0;
			alive_q <= '1;
			dig1_q  <= 5'd0;
		end else if (in_fire) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (data_byte == CHAR_DOLLAR) begin
						phase_q <= PH_DATA;
						sum_q   <= 8'h00;
						pos_q   <= 4'd0;
						alive_q <= '1;
						dig1_q  <= 5'd0;
					end
				end
				PH_DATA: begin
					if (data_byte == CHAR_HASH) begin
						phase_q <= PH_DIG1;
					end else begin
						sum_q   <= sum_q + data_byte;
						alive_q <= alive_next;
						if (pos_q != 4'd15) begin
							pos_q <= pos_q + 4'd1;
						end
					end
				end
				PH_DIG1: begin
					phase_q <= PH_DIG2;
					dig1_q  <= hex[4] ? hex : 5'd0;
				end
				PH_DIG2: begin
					phase_q <= PH_IDLE;
					sum_q   <= 8'h00;
					pos_q   <= 4'd0;
					alive_q <= '1;
					dig1_q  <= 5'd0;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	// Stage one: the counter read issued on the finishing transfer returns here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			cls_s1  <= cls;
			ok_s1   <= ok;
			csum_s1 <= sum_q;
			rsum_s1 <= rsum;
		end
	end

	rpcc_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (NUM_CLASSES)
	) u_counters (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cls_s1),
		.wdata (new_count),
		.raddr (cls),
		.rdata (ram_rdata)
	);

	assign cur_count = cnt_valid_q[cls_s1] ? ram_rdata : '0;
	assign ram_we    = valid_s1 && ok_s1 && !(&cur_count);
	assign new_count = ram_we ? cur_count + COUNT_WIDTH'(1) : cur_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_valid_q <= '0;
		end else if (ram_we) begin
			cnt_valid_q[cls_s1] <= 1'b1;
		end
	end

	// Two-entry result queue decouples the output handshake from the counter update.
	assign pop       = out_valid && out_ready;
	assign out_valid = (q_count_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q    <= 1'b0;
			q_rd_q    <= 1'b0;
			q_count_q <= 2'd0;
		end else begin
			if (valid_s1) begin
				q_wr_q <= !q_wr_q;
			end
			if (pop) begin
				q_rd_q <= !q_rd_q;
			end
			q_count_q <= q_count_q + {1'b0, valid_s1} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			q_cls_q[q_wr_q]    <= cls_s1;
			q_ok_q[q_wr_q]     <= ok_s1;
			q_csum_q[q_wr_q]   <= csum_s1;
			q_rsum_q[q_wr_q]   <= rsum_s1;
			q_clscnt_q[q_wr_q] <= new_count;
		end
	end

	assign command_class = q_cls_q[q_rd_q];
	assign checksum_ok   = q_ok_q[q_rd_q];
	assign computed_sum  = q_csum_q[q_rd_q];
	assign received_sum  = q_rsum_q[q_rd_q];
	assign class_count   = q_clscnt_q[q_rd_q];

	// Frames are at least four bytes long, so two counter updates are never adjacent.
	a_rmw_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> !valid_s1)
		else $error("counter read-modify-write issued on consecutive cycles");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (q_count_q != 2'd2))
		else $error("result pushed into a full output queue");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> out_valid)
		else $error("result entered the queue but is not offered");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (new_count != '0))
		else $error("counter increment wrapped to zero");

endmodule

FILE: hdl/rpcc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module rpcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sim/rsp_packet_checker_counter_core_tb.sv
// Testbench for the RSP packet checker: byte stream stimulus, frame result prediction and checks.
module rsp_packet_checker_counter_core_tb;

	import rpcc_pkg::*;

	localparam int COUNT_W     = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum logic [1:0] {HUNT, IN_DATA, CSUM_HI, CSUM_LO} frame_phase_t;

	typedef struct packed {
		logic [CLASS_W-1:0] cls;
		logic               ok;
		logic [7:0]         csum;
		logic [7:0]         rsum;
		logic [COUNT_W-1:0] count;
	} frame_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          data_byte = 8'h00;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CLASS_W-1:0]  command_class;
	logic                checksum_ok;
	logic [7:0]          computed_sum;
	logic [7:0]          received_sum;
	logic [COUNT_W-1:0]  class_count;

	// Command prefixes in priority order; the class is the index of the first full match.
	string cmd_prefix [NUM_PREFIXES] = '{
		"qSupported", "qTStatus", "qXfer", "qRcmd", "QStartNoAckMode",
		"vMustReplyEmpty", "vCont", "?", "g", "G", "m", "M", "c", "s", "!",
		"Hg", "Hc", "OK", "E", "S", "T", "W", "O"
	};

	// Predicted framer state and per-class packet tallies.
	frame_phase_t             phase = HUNT;
	logic [7:0]               frame_sum = 8'h00;
	int                       frame_pos = 0;
	logic [NUM_PREFIXES-1:0]  prefix_live = '1;
	logic                     hi_digit_ok = 1'b0;
	logic [3:0]               hi_digit = 4'h0;
	logic [COUNT_W-1:0]       class_tally [NUM_CLASSES] = '{default: '0};

	frame_result_t expected_frames [$];
	frame_result_t head_frame;

	int fail_count = 0;
	int cycle_count = 0;
	int stream_bytes = 0;
	int valid_idle_pct = 9;
	int ready_idle_pct = 9;
	int stall_asks = 0;
	int stall_done = 0;
	int stall_left = 0;

	rsp_packet_checker_counter_core #(
		.COUNT_WIDTH(COUNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.command_class(command_class),
		.checksum_ok(checksum_ok),
		.computed_sum(computed_sum),
		.received_sum(received_sum),
		.class_count(class_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d frames outstanding", cycle_count,
				expected_frames.size());
			$display("status: fail");
			$finish;
		end
	end

	// Value of an ASCII hex digit, or -1 when the byte is not one.
	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10) return 8'("0") + 8'(v);
		return (upper ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
	endfunction

	function automatic void predict_byte(input logic [7:0] b);
		int            hv;
		int            cls;
		logic          both_ok;
		logic [7:0]    rsum;
		logic [7:0]    ch;
		frame_result_t r;
		case (phase)
			HUNT: begin
				if (b == CHAR_DOLLAR) phase = IN_DATA;
			end
			IN_DATA: begin
				if (b == CHAR_HASH) begin
					phase = CSUM_HI;
				end else begin
					frame_sum = frame_sum + b;
					for (int i = 0; i < NUM_PREFIXES; i++) begin
						if (frame_pos < cmd_prefix[i].len()) begin
							ch = cmd_prefix[i][frame_pos];
							if (ch != b) prefix_live[i] = 1'b0;
						end
					end
					if (frame_pos < PREFIX_MAX) frame_pos++;
				end
			end
			CSUM_HI: begin
				hv = hex_digit(b);
				hi_digit_ok = (hv >= 0);
				hi_digit = hi_digit_ok ? hv[3:0] : 4'h0;
				phase = CSUM_LO;
			end
			CSUM_LO: begin
				hv = hex_digit(b);
				both_ok = hi_digit_ok && (hv >= 0);
				rsum = both_ok ? {hi_digit, hv[3:0]} : 8'h00;
				cls = int'(CLASS_UNKNOWN);
				// Walk downward so the lowest matching index is the one that sticks.
				for (int i = NUM_PREFIXES - 1; i >= 0; i--) begin
					if (prefix_live[i] && frame_pos >= cmd_prefix[i].len()) cls = i;
				end
				r.ok = both_ok && (rsum == frame_sum);
				if (r.ok && class_tally[cls] != '1) class_tally[cls]++;
				r.cls = CLASS_W'(cls);
				r.csum = frame_sum;
				r.rsum = rsum;
				r.count = class_tally[cls];
				expected_frames.push_back(r);
				phase = HUNT;
				frame_sum = 8'h00;
				frame_pos = 0;
				prefix_live = '1;
				hi_digit_ok = 1'b0;
				hi_digit = 4'h0;
			end
		endcase
	endfunction

	// Output side: random ready, plus a long hold-off whenever a test asks for one.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_asks != stall_done) begin
			out_ready <= 1'b0;
			stall_left <= HOLD_CYCLES;
			stall_done <= stall_asks;
		end else begin
			out_ready <= ($urandom_range(99) >= ready_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_frames.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: class %0d ok %0d sum %02h rx %02h count %0d",
						command_class, checksum_ok, computed_sum, received_sum, class_count);
			end else begin
				head_frame = expected_frames.pop_front();
				if (command_class !== head_frame.cls || checksum_ok !== head_frame.ok ||
						computed_sum !== head_frame.csum || received_sum !== head_frame.rsum ||
						class_count !== head_frame.count) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch: exp class %0d ok %0d sum %02h rx %02h count %0d",
							head_frame.cls, head_frame.ok, head_frame.csum, head_frame.rsum,
							head_frame.count);
						$display("          got class %0d ok %0d sum %02h rx %02h count %0d",
							command_class, checksum_ok, computed_sum, received_sum,
							class_count);
					end
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < valid_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_byte(b);
		stream_bytes++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// One frame aimed at class cls: mostly good checksums, some wrong ones, some non-hex digits.
	task automatic send_random_frame(input int cls);
		logic [7:0] pkt [$];
		logic [7:0] total;
		logic [7:0] c;
		logic [7:0] csum;
		int         keep;
		int         tail;
		int         roll;
		bit         upper;
		total = 8'h00;
		if (cls < NUM_PREFIXES) begin
			keep = cmd_prefix[cls].len();
			if ($urandom_range(9) == 0) keep = $urandom_range(keep);
			for (int i = 0; i < keep; i++) pkt.push_back(cmd_prefix[cls][i]);
			tail = $urandom_range(4);
		end else begin
			tail = $urandom_range(8);
		end
		for (int i = 0; i < tail; i++) begin
			c = 8'($urandom_range(255));
			if (c == CHAR_HASH) c = CHAR_DOLLAR;
			pkt.push_back(c);
		end
		send_byte(CHAR_DOLLAR);
		foreach (pkt[i]) begin
			total = total + pkt[i];
			send_byte(pkt[i]);
		end
		send_byte(CHAR_HASH);
		roll = $urandom_range(99);
		upper = 1'($urandom_range(1));
		if (roll < 90) begin
			csum = (roll < 80) ? total : total + 8'($urandom_range(1, 255));
			send_byte(hex_char(csum[7:4], upper));
			send_byte(hex_char(csum[3:0], upper));
		end else begin
			send_byte(8'($urandom_range(255)));
			send_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic test_directed();
		valid_idle_pct = 9;
		ready_idle_pct = 9;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("$#00");
		send_text("$$#24");
		send_text("$##$");
		send_text("$?#3f");
		send_text("$OK#9A");
		send_text("$#0g");
	endtask

	// The receiver stalls long enough for the result queue to fill and stop the input.
	task automatic test_output_backpressure();
		valid_idle_pct = 0;
		stall_asks++;
		repeat (12) send_random_frame($urandom_range(NUM_CLASSES - 1));
		valid_idle_pct = 9;
	endtask

	// Shortest frames at full rate on both sides, so counter updates follow each other closely.
	task automatic test_back_to_back_frames();
		valid_idle_pct = 0;
		ready_idle_pct = 0;
		repeat (40) send_text("$#00");
		send_text("$#01");
		valid_idle_pct = 9;
		ready_idle_pct = 9;
	endtask

	task automatic test_random_frames();
		int start;
		int frames;
		int roll;
		start = stream_bytes;
		frames = 0;
		while (stream_bytes - start < 280) begin
			roll = $urandom_range(99);
			if (roll < 10) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
			end else if (roll < 13) begin
				// Broken frame: it has no end marker of its own, so it runs into the next frame.
				send_byte(CHAR_DOLLAR);
				repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
			end
			// Sweep every class once before picking them at random.
			send_random_frame(frames < NUM_CLASSES ? frames : $urandom_range(NUM_CLASSES - 1));
			frames++;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_output_backpressure();
		test_back_to_back_frames();
		test_random_frames();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d failing results", fail_count);
			$display("status: fail");
		end
		$finish;
	end

endmodule
